>>> hw/rtl/crom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crom_pkg
// Shared types, widths and helpers for the Catmull-Rom interpolator pipeline.
// ----------------------------------------------------------------------------
package crom_pkg;

  localparam int T_FRAC_BITS = 16;
  localparam int T_W         = T_FRAC_BITS + 1;
  localparam int VAL_W       = 32;
  localparam int H_W         = 38;
  localparam int P_W         = H_W + T_W + 1;

  localparam logic [T_W-1:0]   T_ONE   = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]              axis;
    logic signed [VAL_W-1:0] before_value;
    logic signed [VAL_W-1:0] start_value;
    logic signed [VAL_W-1:0] end_value;
    logic signed [VAL_W-1:0] after_value;
    logic                    before_present;
    logic                    after_present;
    logic [T_W-1:0]          position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              axis_out;
    logic signed [VAL_W-1:0] point_value;
    logic                    clipped;
  } out_item_t;

  typedef struct packed {
    logic [1:0]            axis;
    logic [T_W-1:0]        t;
    logic signed [H_W-1:0] b;
    logic signed [H_W-1:0] c;
    logic signed [H_W-1:0] p1x2;
  } side_t;

  function automatic logic signed [H_W-1:0] sext_val(input logic [VAL_W-1:0] v);
    sext_val = signed'({{(H_W-VAL_W){v[VAL_W-1]}}, v});
  endfunction

endpackage

>>> hw/rtl/crom_coef.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crom_coef
// First pipeline stage: end point substitution, parameter clamp and the
// cubic coefficients a, b, c and 2*p1.
// ----------------------------------------------------------------------------
module crom_coef
  import crom_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  in_item_t              up_data,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output logic signed [H_W-1:0] dn_h,
  output side_t                 dn_side
);

  logic                  valid_r;
  logic signed [H_W-1:0] h_r;
  side_t                 side_r;

  logic signed [H_W-1:0] p0, p1, p2, p3, d12;
  logic signed [H_W-1:0] a_nxt;
  side_t                 side_nxt;

  assign up_stall = valid_r && dn_stall;

  always_comb begin
    p1  = sext_val(up_data.start_value);
    p2  = sext_val(up_data.end_value);
    p0  = up_data.before_present ? sext_val(up_data.before_value) : p1;
    p3  = up_data.after_present  ? sext_val(up_data.after_value)  : p2;
    d12 = p1 - p2;
    a_nxt         = (p3 - p0) + (d12 <<< 1) + d12;
    side_nxt.axis = up_data.axis;
    side_nxt.t    = (up_data.position > T_ONE) ? T_ONE : up_data.position;
    side_nxt.b    = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
    side_nxt.c    = p2 - p0;
    side_nxt.p1x2 = p1 <<< 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      h_r    <= a_nxt;
      side_r <= side_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_h     = h_r;
  assign dn_side  = side_r;

endmodule

>>> hw/rtl/crom_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crom_step
// One Horner step in two stages: h*t, then round to nearest and add the
// next coefficient.
// ----------------------------------------------------------------------------
module crom_step
  import crom_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  logic signed [H_W-1:0] up_h,
  input  logic signed [H_W-1:0] up_addend,
  input  side_t                 up_side,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output logic signed [H_W-1:0] dn_h,
  output side_t                 dn_side
);

  localparam logic signed [P_W-1:0] HALF = P_W'(1) <<< (T_FRAC_BITS - 1);

  logic                  mul_valid_r;
  logic signed [P_W-1:0] prod_r;
  logic signed [H_W-1:0] add_r;
  side_t                 mul_side_r;

  logic                  sum_valid_r;
  logic signed [H_W-1:0] h_r;
  side_t                 sum_side_r;

  logic                  mul_stall, sum_stall;
  logic signed [T_W:0]   t_s;
  logic signed [P_W-1:0] prod_nxt, rnd_full;
  logic signed [H_W-1:0] h_nxt;

  assign sum_stall = sum_valid_r && dn_stall;
  assign mul_stall = mul_valid_r && sum_stall;
  assign up_stall  = mul_stall;

  assign t_s      = signed'({1'b0, up_side.t});
  assign prod_nxt = P_W'(up_h) * P_W'(t_s);
  assign rnd_full = (prod_r + HALF) >>> T_FRAC_BITS;
  assign h_nxt    = signed'(rnd_full[H_W-1:0]) + add_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      sum_valid_r <= 1'b0;
    end else begin
      if (!mul_stall) begin
        mul_valid_r <= up_valid;
      end
      if (!sum_stall) begin
        sum_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!mul_stall && up_valid) begin
      prod_r     <= prod_nxt;
      add_r      <= up_addend;
      mul_side_r <= up_side;
    end
    if (!sum_stall && mul_valid_r) begin
      h_r        <= h_nxt;
      sum_side_r <= mul_side_r;
    end
  end

  assign dn_valid = sum_valid_r;
  assign dn_h     = h_r;
  assign dn_side  = sum_side_r;

endmodule

>>> hw/rtl/catmull_rom_interpolator.sv
`timescale 1ns / 1ps
// stages: coefficient stage, three two-stage horner steps, output register
// throughput: one transaction per cycle while out_stall is low; each stage
// holds only while its successor is full and stalled, so bubbles close up
// reset: synchronous active-low rst_n clears all stage valid bits
// ----------------------------------------------------------------------------
// catmull_rom_interpolator
// Uniform Catmull-Rom interpolation of one coordinate per transaction with
// rounding Horner evaluation and 32-bit saturation.
// ----------------------------------------------------------------------------
module catmull_rom_interpolator
  import crom_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic                  c_valid, c_stall;
  logic signed [H_W-1:0] c_h;
  side_t                 c_side;

  logic                  s0_valid, s0_stall;
  logic signed [H_W-1:0] s0_h;
  side_t                 s0_side;

  logic                  s1_valid, s1_stall;
  logic signed [H_W-1:0] s1_h;
  side_t                 s1_side;

  logic                  s2_valid, s2_stall;
  logic signed [H_W-1:0] s2_h;
  side_t                 s2_side;

  logic                  out_valid_r;
  out_item_t             out_data_r;
  out_item_t             out_nxt;
  logic signed [H_W-1:0] r_full;
  logic                  fits;

  crom_coef u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (c_valid),
    .dn_stall (c_stall),
    .dn_h     (c_h),
    .dn_side  (c_side)
  );

  crom_step u_step0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (c_valid),
    .up_stall  (c_stall),
    .up_h      (c_h),
    .up_addend (c_side.b),
    .up_side   (c_side),
    .dn_valid  (s0_valid),
    .dn_stall  (s0_stall),
    .dn_h      (s0_h),
    .dn_side   (s0_side)
  );

  crom_step u_step1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s0_valid),
    .up_stall  (s0_stall),
    .up_h      (s0_h),
    .up_addend (s0_side.c),
    .up_side   (s0_side),
    .dn_valid  (s1_valid),
    .dn_stall  (s1_stall),
    .dn_h      (s1_h),
    .dn_side   (s1_side)
  );

  crom_step u_step2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s1_valid),
    .up_stall  (s1_stall),
    .up_h      (s1_h),
    .up_addend (s1_side.p1x2),
    .up_side   (s1_side),
    .dn_valid  (s2_valid),
    .dn_stall  (s2_stall),
    .dn_h      (s2_h),
    .dn_side   (s2_side)
  );

  assign s2_stall = out_valid_r && out_stall;

  always_comb begin
    r_full = (s2_h + H_W'(1)) >>> 1;
    fits   = (&r_full[H_W-1:VAL_W-1]) || !(|r_full[H_W-1:VAL_W-1]);
    out_nxt.axis_out = s2_side.axis;
    out_nxt.clipped  = !fits;
    if (fits) begin
      out_nxt.point_value = signed'(r_full[VAL_W-1:0]);
    end else if (r_full[H_W-1]) begin
      out_nxt.point_value = signed'(VAL_MIN);
    end else begin
      out_nxt.point_value = signed'(VAL_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!s2_stall) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s2_stall && s2_valid) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/crom_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crom_checker
// Port-level assertions for the Catmull-Rom interpolator, bound to the top.
// ----------------------------------------------------------------------------
module crom_checker
  import crom_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clipped |->
      (out_data.point_value == signed'(VAL_MAX) ||
       out_data.point_value == signed'(VAL_MIN)))
    else $error("clipped result not at a saturation bound");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && !in_stall) && !out_stall) [*8] |=> !out_valid)
    else $error("output transaction without an input transaction");

  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

endmodule

bind catmull_rom_interpolator crom_checker u_crom_checker (.*);
